>>> src/region_bump_suballocator_macros.svh
// Assertion macros for the region bump suballocator checker.
// Used by rbs_checker; needs clk and rst in the including scope.
`ifndef REGION_BUMP_SUBALLOCATOR_MACROS_SVH
`define REGION_BUMP_SUBALLOCATOR_MACROS_SVH

// same-cycle implication
`define RBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rbs_pkg.sv
// Shared types and constants for the region bump suballocator.
// No dependencies.
package rbs_pkg;

  localparam int SLOT_W = 8;
  localparam logic [30:0] ID_LIMIT = 31'h7FFF_FFFF;
  localparam logic [6:0] ACTIVE_LIMIT = 7'd127;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE = 2'd1;

  localparam logic [1:0] CFG_REGION_SIZE = 2'd0;
  localparam logic [1:0] CFG_DED_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_MIXED_GRAN = 2'd2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL = 2'd2,
    ST_ID_ZERO = 2'd3
  } status_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_FINISH} state_t;

  typedef enum logic [1:0] {RC_NONE, RC_OPEN, RC_BUMP, RC_FREE} rop_t;
  typedef enum logic [1:0] {DC_NONE, DC_ALLOC, DC_FREE} dop_t;

  typedef struct packed {
    rop_t op;
    logic [SLOT_W-1:0] idx;
    logic [30:0] first;
    logic [31:0] fill;
    logic lin;
  } rcmd_t;

  typedef struct packed {
    logic live_found;
    logic [30:0] best_first;
    logic [SLOT_W-1:0] best_idx;
    logic free_found;
    logic [SLOT_W-1:0] free_idx;
  } rtok_t;

  typedef struct packed {
    logic live;
    logic [30:0] first;
    logic [6:0] active;
    logic [31:0] fill;
    logic last_lin;
  } rview_t;

  typedef struct packed {
    dop_t op;
    logic [SLOT_W-1:0] idx;
    logic [30:0] key;
    logic [31:0] len;
  } dcmd_t;

  typedef struct packed {
    logic hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [31:0] hit_len;
    logic free_found;
    logic [SLOT_W-1:0] free_idx;
  } dtok_t;

endpackage

>>> src/rbs_region_cell.sv
// One region slot: holds the region state and passes the search token on.
// Depends on rbs_pkg.
module rbs_region_cell import rbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] my_idx,
  input  rcmd_t             cmd,
  input  rtok_t             tok_in,
  output rtok_t             tok_out,
  output rview_t            view
);

  logic        live;
  logic [30:0] first;
  logic [6:0]  active;
  logic [31:0] fill;
  logic        last_lin;
  logic        sel;
  logic [6:0]  active_dec;
  rtok_t       tok_next;

  assign sel = (cmd.idx == my_idx);
  assign active_dec = (active != 7'd0) ? active - 7'd1 : 7'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (sel) begin
      case (cmd.op)
        RC_OPEN: live <= 1'b1;
        RC_FREE: if (active_dec == 7'd0) live <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      case (cmd.op)
        RC_OPEN: begin
          first <= cmd.first;
          active <= 7'd1;
          fill <= cmd.fill;
          last_lin <= cmd.lin;
        end
        RC_BUMP: begin
          active <= active + 7'd1;
          fill <= cmd.fill;
          last_lin <= cmd.lin;
        end
        RC_FREE: active <= active_dec;
        default: ;
      endcase
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (live && (!tok_in.live_found || first > tok_in.best_first)) begin
      tok_next.live_found = 1'b1;
      tok_next.best_first = first;
      tok_next.best_idx = my_idx;
    end
    if (!tok_in.free_found && !live) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  assign view = '{live: live, first: first, active: active, fill: fill, last_lin: last_lin};

endmodule

>>> src/rbs_ded_cell.sv
// One dedicated slot: holds key and length, matches the searched key.
// Depends on rbs_pkg.
module rbs_ded_cell import rbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] my_idx,
  input  logic [31:0]       mag,
  input  dcmd_t             cmd,
  input  dtok_t             tok_in,
  output dtok_t             tok_out
);

  logic        live;
  logic [30:0] key;
  logic [31:0] len;
  logic        sel;
  dtok_t       tok_next;

  assign sel = (cmd.idx == my_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (sel) begin
      case (cmd.op)
        DC_ALLOC: live <= 1'b1;
        DC_FREE: live <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.op == DC_ALLOC) begin
      key <= cmd.key;
      len <= cmd.len;
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && live && {1'b0, key} == mag) begin
      tok_next.hit = 1'b1;
      tok_next.hit_idx = my_idx;
      tok_next.hit_len = len;
    end
    if (!tok_in.free_found && !live) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> src/rbs_rem_unit.sv
// Bit-serial remainder unit: 32-bit dividend modulo 17-bit divisor.
// One quotient bit per cycle. Depends on rbs_pkg.
module rbs_rem_unit import rbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [16:0] rem
);

  logic        run;
  logic [4:0]  cnt;
  logic [31:0] shreg;
  logic [16:0] dsr;
  logic [17:0] part;
  logic [17:0] part_sub;

  assign part = {rem, shreg[31]};
  assign part_sub = (part >= {1'b0, dsr}) ? part - {1'b0, dsr} : part;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      shreg <= dividend;
      dsr <= divisor;
    end else if (run) begin
      rem <= part_sub[16:0];
      shreg <= {shreg[30:0], 1'b0};
    end
  end

endmodule

>>> src/region_bump_suballocator.sv
// Region bump suballocator: one allocate, free or lookup per command. A request
// is taken when start is high and busy low; its single result appears on the
// output ports for exactly one cycle with done high and cannot be held off.
// Every request walks the entry table one entry per cycle through its memory
// read port while the region and dedicated slot chains settle; a shared
// allocation that lands in a live region then also waits for the serial
// remainder unit. busy is low again while done is high. No clearing pass after
// reset. Depends on rbs_pkg, rbs_region_cell, rbs_ded_cell and rbs_rem_unit.
module region_bump_suballocator import rbs_pkg::*; #(
  parameter int MAX_REGIONS = 16,
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_DEDICATED = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [31:0]        req_size,
  input  logic [16:0]        req_alignment,
  input  logic               req_linear,
  input  logic signed [31:0] target_id,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] result_id,
  output logic               is_dedicated,
  output logic [3:0]         slot_index,
  output logic [31:0]        byte_offset,
  output logic [31:0]        byte_size,
  output logic               opened_region,
  output logic               released_slot
);

  localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LONGEST = (MAX_ENTRIES >= MAX_REGIONS && MAX_ENTRIES >= MAX_DEDICATED)
                           ? MAX_ENTRIES
                           : ((MAX_REGIONS >= MAX_DEDICATED) ? MAX_REGIONS : MAX_DEDICATED);
  localparam int SCAN_LEN = LONGEST + 2;
  localparam int CW = $clog2(SCAN_LEN + 1);

  typedef struct packed {
    logic [30:0]   key;
    logic [31:0]   start;
    logic [31:0]   length;
    logic [RW-1:0] home;
  } entry_t;

  // configuration
  logic [31:0] region_size;
  logic [31:0] ded_threshold;
  logic [16:0] mixed_gran;

  // request
  logic [1:0]  cur_type;
  logic [31:0] cur_size;
  logic [16:0] cur_align;
  logic        cur_lin;
  logic [31:0] cur_tid;
  logic [31:0] cur_mag;

  state_t      state, state_next;
  logic [CW-1:0] cnt;
  logic [30:0] ded_issued;
  logic [30:0] sh_issued;

  // entry table
  entry_t            ent_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_live;
  entry_t            ent_rd;
  logic              rd_vld;
  logic              rd_live;
  logic [EW-1:0]     rd_idx;
  logic              ent_hit;
  logic [EW-1:0]     ent_hit_idx;
  entry_t            ent_hit_data;
  logic              ent_free_found;
  logic [EW-1:0]     ent_free_idx;
  logic              rd_en;

  // chains
  rtok_t  rchain [MAX_REGIONS+1];
  rview_t rview  [MAX_REGIONS];
  dtok_t  dchain [MAX_DEDICATED+1];
  rtok_t  rtok;
  dtok_t  dtok;
  rcmd_t  rcmd;
  dcmd_t  dcmd;
  rview_t view;
  logic [SLOT_W-1:0] rd_slot;

  // remainder
  logic        rem_go;
  logic        rem_done;
  logic [16:0] rem;
  logic [16:0] a_eff;
  logic [16:0] a_eff_next;
  logic [16:0] align1;
  logic [16:0] gran1;

  // finish
  logic        shared;
  logic        do_free;
  logic [32:0] off_raw;
  logic        fits;
  logic        fresh;
  logic        ent_we;
  logic        ent_clr;
  logic        ded_inc;
  logic        sh_inc;
  logic [SLOT_W-1:0] fin_slot;
  status_t     r_status;
  logic [31:0] r_id;
  logic        r_ded;
  logic [SLOT_W-1:0] r_slot;
  logic [31:0] r_off;
  logic [31:0] r_size;
  logic        r_open;
  logic        r_rel;

  assign shared = (cur_type == REQ_ALLOC) && (cur_size < ded_threshold);
  assign do_free = (cur_type == REQ_FREE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= 32'd67108864;
      ded_threshold <= 32'd16777216;
      mixed_gran <= 17'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_SIZE: region_size <= cfg_data;
        CFG_DED_THRESHOLD: ded_threshold <= cfg_data;
        CFG_MIXED_GRAN: mixed_gran <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur_type <= req_type;
      cur_size <= req_size;
      cur_align <= req_alignment;
      cur_lin <= req_linear;
      cur_tid <= target_id;
      cur_mag <= 32'd0 - target_id;
    end
  end

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_SCAN;
      S_SCAN: begin
        if (cnt == CW'(SCAN_LEN - 1)) begin
          state_next = (shared && rtok.live_found) ? S_DIV : S_FINISH;
        end
      end
      S_DIV: if (rem_done) state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    rem_go = (state == S_SCAN) && (state_next == S_DIV);
    rd_en = (state == S_SCAN) && (cnt < CW'(MAX_ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= (state == S_SCAN) ? cnt + 1'b1 : '0;
    end
  end

  // entry walk
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ent_rd <= ent_mem[cnt[EW-1:0]];
      rd_live <= entry_live[cnt[EW-1:0]];
      rd_idx <= cnt[EW-1:0];
    end
    if (ent_we) begin
      ent_mem[ent_free_idx] <= '{key: sh_issued + 31'd1, start: r_off,
                                 length: cur_size, home: fin_slot[RW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      ent_hit <= 1'b0;
      ent_free_found <= 1'b0;
      entry_live <= '0;
    end else begin
      rd_vld <= rd_en;
      if (state == S_IDLE && start) begin
        ent_hit <= 1'b0;
        ent_free_found <= 1'b0;
      end else if (rd_vld) begin
        if (!ent_free_found && !rd_live) begin
          ent_free_found <= 1'b1;
        end
        if (!ent_hit && rd_live && {1'b0, ent_rd.key} == cur_tid) begin
          ent_hit <= 1'b1;
        end
      end
      if (ent_we) entry_live[ent_free_idx] <= 1'b1;
      if (ent_clr) entry_live[ent_hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && !ent_free_found && !rd_live) ent_free_idx <= rd_idx;
    if (rd_vld && !ent_hit && rd_live && {1'b0, ent_rd.key} == cur_tid) begin
      ent_hit_idx <= rd_idx;
      ent_hit_data <= ent_rd;
    end
  end

  // region and dedicated chains
  assign rchain[0] = '0;
  assign dchain[0] = '0;

  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_region
    rbs_region_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .my_idx (SLOT_W'(g)),
      .cmd    (rcmd),
      .tok_in (rchain[g]),
      .tok_out(rchain[g+1]),
      .view   (rview[g])
    );
  end

  for (genvar g = 0; g < MAX_DEDICATED; g++) begin : g_ded
    rbs_ded_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .my_idx (SLOT_W'(g)),
      .mag    (cur_mag),
      .cmd    (dcmd),
      .tok_in (dchain[g]),
      .tok_out(dchain[g+1])
    );
  end

  assign rtok = rchain[MAX_REGIONS];
  assign dtok = dchain[MAX_DEDICATED];

  assign rd_slot = (cur_type == REQ_ALLOC) ? rtok.best_idx : SLOT_W'(ent_hit_data.home);
  assign view = rview[rd_slot[RW-1:0]];

  // alignment step
  assign align1 = (cur_align == 17'd0) ? 17'd1 : cur_align;
  assign gran1 = (mixed_gran == 17'd0) ? 17'd1 : mixed_gran;
  assign a_eff_next = (cur_lin != view.last_lin && gran1 > align1) ? gran1 : align1;

  always_ff @(posedge clk) begin
    if (rem_go) a_eff <= a_eff_next;
  end

  rbs_rem_unit u_rem (
    .clk     (clk),
    .rst     (rst),
    .go      (rem_go),
    .dividend(view.fill),
    .divisor (a_eff_next),
    .done    (rem_done),
    .rem     (rem)
  );

  // result and table updates
  always_comb begin
    r_status = ST_OK;
    r_id = '0;
    r_ded = 1'b0;
    r_slot = '0;
    r_off = '0;
    r_size = '0;
    r_open = 1'b0;
    r_rel = 1'b0;
    rcmd = '{op: RC_NONE, idx: '0, first: '0, fill: '0, lin: 1'b0};
    dcmd = '{op: DC_NONE, idx: '0, key: '0, len: '0};
    ent_we = 1'b0;
    ent_clr = 1'b0;
    ded_inc = 1'b0;
    sh_inc = 1'b0;
    off_raw = (rem == 17'd0) ? {1'b0, view.fill} : {1'b0, view.fill} + 33'(a_eff - rem);
    fits = rtok.live_found && (view.active < ACTIVE_LIMIT)
           && ({1'b0, off_raw} + {2'b0, cur_size}) <= {2'b0, region_size};
    fresh = !fits;
    fin_slot = fresh ? rtok.free_idx : rtok.best_idx;
    if (state == S_FINISH) begin
      if (cur_type == REQ_ALLOC) begin
        if (!shared) begin
          if (dtok.free_found && ded_issued != ID_LIMIT) begin
            r_id = 32'd0 - {1'b0, ded_issued + 31'd1};
            r_ded = 1'b1;
            r_slot = dtok.free_idx;
            r_size = cur_size;
            r_open = 1'b1;
            dcmd = '{op: DC_ALLOC, idx: dtok.free_idx, key: ded_issued + 31'd1,
                     len: cur_size};
            ded_inc = 1'b1;
          end else begin
            r_status = ST_FULL;
          end
        end else if (sh_issued != ID_LIMIT && ent_free_found
                     && (!fresh || (cur_size <= region_size && rtok.free_found))) begin
          r_id = {1'b0, sh_issued + 31'd1};
          r_slot = fin_slot;
          r_off = fresh ? 32'd0 : off_raw[31:0];
          r_size = cur_size;
          r_open = fresh;
          rcmd = '{op: RC_BUMP, idx: fin_slot,
                   first: sh_issued + 31'd1,
                   fill: (fresh ? 32'd0 : off_raw[31:0]) + cur_size, lin: cur_lin};
          if (fresh) rcmd.op = RC_OPEN;
          ent_we = 1'b1;
          sh_inc = 1'b1;
        end else begin
          r_status = ST_FULL;
        end
      end else if (cur_tid == 32'd0) begin
        r_status = ST_ID_ZERO;
      end else begin
        r_id = cur_tid;
        if (cur_tid[31]) begin
          if (dtok.hit) begin
            r_ded = 1'b1;
            r_slot = dtok.hit_idx;
            r_size = dtok.hit_len;
            r_rel = do_free;
            if (do_free) begin
              dcmd = '{op: DC_FREE, idx: dtok.hit_idx, key: '0, len: '0};
            end
          end else begin
            r_status = ST_NOT_FOUND;
          end
        end else if (ent_hit) begin
          r_slot = SLOT_W'(ent_hit_data.home);
          r_off = ent_hit_data.start;
          r_size = ent_hit_data.length;
          if (do_free) begin
            r_rel = (view.active <= 7'd1);
            rcmd = '{op: RC_FREE, idx: SLOT_W'(ent_hit_data.home), first: '0,
                     fill: '0, lin: 1'b0};
            ent_clr = 1'b1;
          end
        end else begin
          r_status = ST_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ded_issued <= '0;
      sh_issued <= '0;
      done <= 1'b0;
    end else begin
      if (ded_inc) ded_issued <= ded_issued + 31'd1;
      if (sh_inc) sh_issued <= sh_issued + 31'd1;
      done <= (state == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      status <= r_status;
      result_id <= r_id;
      is_dedicated <= r_ded;
      slot_index <= r_slot[3:0];
      byte_offset <= r_off;
      byte_size <= r_size;
      opened_region <= r_open;
      released_slot <= r_rel;
    end
  end

endmodule

>>> src/rbs_checker.sv
// Port-level checks for region_bump_suballocator, bound to the top level.
// Depends on rbs_pkg and region_bump_suballocator_macros.svh.
`include "region_bump_suballocator_macros.svh"

module rbs_checker import rbs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic               is_dedicated,
  input logic [31:0]        byte_size,
  input logic               opened_region,
  input logic               released_slot
);

  `RBS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `RBS_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while still busy")
  `RBS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `RBS_ASSERT_NOW(a_err_clean, done && status != ST_OK, !is_dedicated && byte_size == 32'd0 && !opened_region && !released_slot, "failed transaction carries payload")
  `RBS_ASSERT_NOW(a_open_ok, done && opened_region, status == ST_OK && !released_slot, "open flag on bad result")

endmodule

bind region_bump_suballocator rbs_checker u_rbs_checker (.*);
